// File: rtl/arqs_pkg.sv
package arqs_pkg;

	localparam int SEQ_BITS = 32;
	localparam int FIELD_BITS = 32;
	localparam int TICK_BITS = 16;
	localparam int QUIET_BITS = 3;
	localparam int CFG_BITS = 16;

	localparam logic [TICK_BITS-1:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [QUIET_BITS-1:0] QUIET_RESET = 3'd2;
	localparam logic [QUIET_BITS-1:0] QUIET_MAX = 3'd7;

	localparam logic [7:0] FLAG_ACK = 8'h02;
	localparam logic [7:0] FLAG_SYNACK = 8'h03;
	localparam logic [7:0] FLAG_FINACK = 8'h0A;

	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_QUIET = 1'b1;

	typedef logic [SEQ_BITS-1:0] seq_t;

	typedef enum logic [2:0] {
		PH_CLOSED = 3'd0,
		PH_SYN = 3'd1,
		PH_HQUIET = 3'd2,
		PH_EST = 3'd3,
		PH_XFER = 3'd4,
		PH_FIN = 3'd5,
		PH_FINACK = 3'd6,
		PH_FQUIET = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		OP_TICK = 3'd0,
		OP_PKT = 3'd1,
		OP_OPEN = 3'd2,
		OP_XFER = 3'd3,
		OP_CLOSE = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		K_SYN = 3'd0,
		K_ACK = 3'd1,
		K_DATA = 3'd2,
		K_FIN = 3'd3,
		K_DONE = 3'd4,
		K_CONN = 3'd5,
		K_CLOSED = 3'd6
	} kind_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] pkt_kind;
		seq_t pkt_seq;
		seq_t pkt_ack;
		logic pkt_sum_ok;
		seq_t final_seq;
	} event_t;

	typedef struct packed {
		logic [2:0] out_kind;
		logic [FIELD_BITS-1:0] out_seq;
		logic [FIELD_BITS-1:0] out_ack;
	} result_t;

	typedef struct packed {
		phase_t phase;
		seq_t send_seq;
		seq_t peer_expected;
		seq_t end_seq;
		logic [TICK_BITS-1:0] tick_count;
		logic [QUIET_BITS-1:0] silent_count;
	} conn_state_t;

	typedef struct packed {
		logic [TICK_BITS-1:0] timeout_ticks;
		logic [QUIET_BITS-1:0] quiet_timeouts;
	} cfg_t;

endpackage

// File: rtl/arqs_step.sv
module arqs_step (
	input arqs_pkg::event_t ev,
	input arqs_pkg::conn_state_t st,
	input arqs_pkg::cfg_t cfg,
	output arqs_pkg::conn_state_t nxt,
	output logic res_valid,
	output arqs_pkg::result_t res
);

	arqs_pkg::seq_t next_seq;
	arqs_pkg::seq_t seq_plus;
	logic [arqs_pkg::TICK_BITS-1:0] tick_inc;
	logic [arqs_pkg::QUIET_BITS-1:0] silent_inc;
	logic fires;
	logic quiet_done;

	assign next_seq = st.send_seq + arqs_pkg::seq_t'(1);
	assign seq_plus = ev.pkt_seq + arqs_pkg::seq_t'(1);
	assign tick_inc = st.tick_count + arqs_pkg::TICK_BITS'(1);
	assign fires = (tick_inc >= cfg.timeout_ticks);
	assign silent_inc = (st.silent_count < arqs_pkg::QUIET_MAX)
		? st.silent_count + arqs_pkg::QUIET_BITS'(1) : st.silent_count;
	assign quiet_done = (silent_inc >= cfg.quiet_timeouts);

	function automatic arqs_pkg::result_t mk(arqs_pkg::kind_t k, arqs_pkg::seq_t s,
			arqs_pkg::seq_t a);
		arqs_pkg::result_t r;
		r.out_kind = k;
		r.out_seq = arqs_pkg::FIELD_BITS'(s);
		r.out_ack = arqs_pkg::FIELD_BITS'(a);
		return r;
	endfunction

	always_comb begin
		nxt = st;
		res_valid = 1'b0;
		res = mk(arqs_pkg::K_SYN, st.send_seq, '0);
		unique case (ev.opcode)
			arqs_pkg::OP_TICK: begin
				if (st.phase != arqs_pkg::PH_CLOSED && st.phase != arqs_pkg::PH_EST) begin
					if (!fires) begin
						nxt.tick_count = tick_inc;
					end else begin
						nxt.tick_count = '0;
						unique case (st.phase)
							arqs_pkg::PH_SYN: begin
								res_valid = 1'b1;
								res = mk(arqs_pkg::K_SYN, st.send_seq, '0);
							end
							arqs_pkg::PH_XFER: begin
								res_valid = 1'b1;
								res = mk(arqs_pkg::K_DATA, st.send_seq, '0);
							end
							arqs_pkg::PH_FIN: begin
								res_valid = 1'b1;
								res = mk(arqs_pkg::K_FIN, st.send_seq, '0);
							end
							arqs_pkg::PH_HQUIET, arqs_pkg::PH_FQUIET: begin
								if (!quiet_done) begin
									nxt.silent_count = silent_inc;
								end else begin
									nxt.silent_count = '0;
									res_valid = 1'b1;
									if (st.phase == arqs_pkg::PH_HQUIET) begin
										nxt.send_seq = next_seq;
										nxt.phase = arqs_pkg::PH_EST;
										res = mk(arqs_pkg::K_CONN, next_seq, st.peer_expected);
									end else begin
										nxt.phase = arqs_pkg::PH_CLOSED;
										res = mk(arqs_pkg::K_CLOSED, st.send_seq,
											st.peer_expected);
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			arqs_pkg::OP_PKT: begin
				if (ev.pkt_sum_ok) begin
					unique case (st.phase)
						arqs_pkg::PH_SYN: begin
							if (ev.pkt_kind == arqs_pkg::FLAG_SYNACK && ev.pkt_ack == next_seq) begin
								nxt.peer_expected = seq_plus;
								nxt.send_seq = next_seq;
								nxt.phase = arqs_pkg::PH_HQUIET;
								nxt.tick_count = '0;
								nxt.silent_count = '0;
								res_valid = 1'b1;
								res = mk(arqs_pkg::K_ACK, next_seq, seq_plus);
							end
						end
						arqs_pkg::PH_HQUIET: begin
							if (ev.pkt_kind == arqs_pkg::FLAG_SYNACK
									&& ev.pkt_ack == st.send_seq) begin
								nxt.tick_count = '0;
								nxt.silent_count = '0;
								res_valid = 1'b1;
								res = mk(arqs_pkg::K_ACK, st.send_seq, st.peer_expected);
							end
						end
						arqs_pkg::PH_XFER: begin
							if (ev.pkt_kind == arqs_pkg::FLAG_ACK) begin
								nxt.tick_count = '0;
								res_valid = 1'b1;
								if (ev.pkt_ack != next_seq) begin
									// wrong ack: resend at once
									res = mk(arqs_pkg::K_DATA, st.send_seq, '0);
								end else begin
									nxt.send_seq = ev.pkt_ack;
									nxt.peer_expected = seq_plus;
									if (st.send_seq == st.end_seq) begin
										nxt.phase = arqs_pkg::PH_EST;
										res = mk(arqs_pkg::K_DONE, ev.pkt_ack, seq_plus);
									end else begin
										res = mk(arqs_pkg::K_DATA, ev.pkt_ack, '0);
									end
								end
							end
						end
						arqs_pkg::PH_FIN: begin
							if (ev.pkt_kind == arqs_pkg::FLAG_ACK && ev.pkt_ack == next_seq) begin
								nxt.send_seq = next_seq;
								nxt.peer_expected = seq_plus;
								nxt.phase = arqs_pkg::PH_FINACK;
								nxt.tick_count = '0;
							end
						end
						arqs_pkg::PH_FINACK: begin
							if (ev.pkt_kind == arqs_pkg::FLAG_FINACK && ev.pkt_ack == st.send_seq
									&& ev.pkt_seq == st.peer_expected) begin
								nxt.peer_expected = seq_plus;
								nxt.phase = arqs_pkg::PH_FQUIET;
								nxt.tick_count = '0;
								nxt.silent_count = '0;
								res_valid = 1'b1;
								res = mk(arqs_pkg::K_ACK, st.send_seq, seq_plus);
							end
						end
						arqs_pkg::PH_FQUIET: begin
							// duplicate FIN-ACK: resend the final ACK
							if (ev.pkt_kind == arqs_pkg::FLAG_FINACK && ev.pkt_ack == st.send_seq
									&& seq_plus == st.peer_expected) begin
								nxt.tick_count = '0;
								nxt.silent_count = '0;
								res_valid = 1'b1;
								res = mk(arqs_pkg::K_ACK, st.send_seq, st.peer_expected);
							end
						end
						default: begin
						end
					endcase
				end
			end
			arqs_pkg::OP_OPEN: begin
				if (st.phase == arqs_pkg::PH_CLOSED) begin
					nxt.send_seq = '0;
					nxt.peer_expected = '0;
					nxt.phase = arqs_pkg::PH_SYN;
					nxt.tick_count = '0;
					nxt.silent_count = '0;
					res_valid = 1'b1;
					res = mk(arqs_pkg::K_SYN, '0, '0);
				end
			end
			arqs_pkg::OP_XFER: begin
				if (st.phase == arqs_pkg::PH_EST) begin
					nxt.end_seq = ev.final_seq;
					nxt.phase = arqs_pkg::PH_XFER;
					nxt.tick_count = '0;
					res_valid = 1'b1;
					res = mk(arqs_pkg::K_DATA, st.send_seq, '0);
				end
			end
			arqs_pkg::OP_CLOSE: begin
				if (st.phase == arqs_pkg::PH_EST) begin
					nxt.phase = arqs_pkg::PH_FIN;
					nxt.tick_count = '0;
					res_valid = 1'b1;
					res = mk(arqs_pkg::K_FIN, st.send_seq, '0);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/arqs_out_fifo.sv
module arqs_out_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input arqs_pkg::result_t push_data,
	output logic room,
	output logic pop_valid,
	input logic pop_ready,
	output arqs_pkg::result_t pop_data
);

	arqs_pkg::result_t mem_q [2];
	logic rd_ptr_q;
	logic wr_ptr_q;
	logic [1:0] count_q;
	logic pop;

	assign room = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/stop_and_wait_arq_sender_core.sv
// Stop-and-wait ARQ sender. Each input transfer is one event (tuser carries
// the opcode: tick, received packet, open, start transfer, close) and gives at
// most one output transfer: a SYN, ACK, DATA or FIN send request, or a status
// report (transfer done, connected, closed), with out_kind on tuser. Events
// that cause nothing give no output transfer. One event is taken every clock
// cycle while the input register is empty or the output buffer has room; an
// event is held in the input register, applied to the connection state by
// combinational logic, and its result enters a two-entry output buffer, from
// which it is offered on the master side. Input readiness depends only on the
// input register being empty or that buffer having room, never combinationally
// on m_axis_tready. Program timeout_ticks (index 0) and quiet_timeouts (index 1)
// only while no event is in flight; reset values are 1000 and 2.
module stop_and_wait_arq_sender_core (
	input logic clk,
	input logic arst_n,

	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// [7:0] pkt_kind, [39:8] pkt_seq, [71:40] pkt_ack, [72] pkt_sum_ok,
	// [104:73] final_seq, [111:105] zero
	input logic [111:0] s_axis_tdata,
	// [2:0] opcode
	input logic [2:0] s_axis_tuser,

	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// [31:0] out_seq, [63:32] out_ack
	output logic [63:0] m_axis_tdata,
	// [2:0] out_kind
	output logic [2:0] m_axis_tuser,

	input logic cfg_we,
	input logic cfg_index,
	input logic [arqs_pkg::CFG_BITS-1:0] cfg_wdata
);

	// Input stage
	arqs_pkg::event_t item_s1;
	logic valid_s1;

	// Connection state and configuration
	arqs_pkg::conn_state_t state_q;
	arqs_pkg::conn_state_t state_nxt;
	arqs_pkg::cfg_t cfg_q;

	arqs_pkg::event_t in_event;
	arqs_pkg::result_t res;
	arqs_pkg::result_t out_item;
	logic res_valid;
	logic room;
	logic advance;

	// Unpack the input transfer; sequence fields keep only SEQ_BITS bits.
	always_comb begin
		in_event.opcode = s_axis_tuser;
		in_event.pkt_kind = s_axis_tdata[7:0];
		in_event.pkt_seq = arqs_pkg::SEQ_BITS'(s_axis_tdata[39:8]);
		in_event.pkt_ack = arqs_pkg::SEQ_BITS'(s_axis_tdata[71:40]);
		in_event.pkt_sum_ok = s_axis_tdata[72];
		in_event.final_seq = arqs_pkg::SEQ_BITS'(s_axis_tdata[104:73]);
	end

	// Apply the held event when the output buffer can take its result.
	assign advance = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= in_event;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	arqs_step u_step (
		.ev(item_s1),
		.st(state_q),
		.cfg(cfg_q),
		.nxt(state_nxt),
		.res_valid(res_valid),
		.res(res)
	);

	// Commit the new connection state once per applied event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= arqs_pkg::PH_CLOSED;
			state_q.send_seq <= '0;
			state_q.peer_expected <= '0;
			state_q.end_seq <= '0;
			state_q.tick_count <= '0;
			state_q.silent_count <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Configuration writes land directly; upper data bits of the quiet count drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= arqs_pkg::TIMEOUT_RESET;
			cfg_q.quiet_timeouts <= arqs_pkg::QUIET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				arqs_pkg::CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_wdata;
				arqs_pkg::CFG_QUIET:
					cfg_q.quiet_timeouts <= cfg_wdata[arqs_pkg::QUIET_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	arqs_out_fifo u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(advance && res_valid),
		.push_data(res),
		.room(room),
		.pop_valid(m_axis_tvalid),
		.pop_ready(m_axis_tready),
		.pop_data(out_item)
	);

	assign m_axis_tuser = out_item.out_kind;
	assign m_axis_tdata = {out_item.out_ack, out_item.out_seq};

endmodule

// File: tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import arqs_pkg::*;

	// Opcodes outside the defined set; the block must ignore them.
	localparam logic [2:0] OP_RSVD_LO = 3'd5;
	localparam logic [2:0] OP_RSVD_HI = 3'd7;

	// A result leaves through the input register and the output buffer; drain well past that.
	localparam int DRAIN_CYCLES = 8;
	localparam int ITEMS_PER_SETTING = 275;
	localparam int NUM_SETTINGS = 7;
	// One long receiver hold-off, once this many sends have gone through.
	localparam int HOLD_AFTER = 400;
	localparam int HOLD_CYCLES = 300;

	typedef enum {ROW_TYPED, ROW_PREDICTED, ROW_CONFIG} row_kind_t;

	typedef struct {
		row_kind_t rk;
		event_t ev;
		bit has_send;
		result_t send;
		logic cfg_idx;
		logic [CFG_BITS-1:0] cfg_val;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [111:0] s_axis_tdata;
	logic [2:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_BITS-1:0] cfg_wdata;

	// Connection state and settings as the sender should see them.
	phase_t arq_phase;
	seq_t tx_seq;
	seq_t rx_next;
	seq_t last_seq;
	logic [TICK_BITS-1:0] tick_cnt;
	logic [QUIET_BITS-1:0] quiet_cnt;
	logic [TICK_BITS-1:0] cfg_timeout;
	logic [QUIET_BITS-1:0] cfg_quiet;

	result_t pending_sends[$];
	script_row_t script[$];
	result_t want;
	int error_count = 0;
	int sends_seen = 0;
	bit steady = 0;
	bit held_off = 0;

	logic [CFG_BITS-1:0] set_timeout[NUM_SETTINGS] =
		'{16'd1, 16'd4, 16'd0, 16'd65535, 16'd2, 16'd1, 16'd3};
	logic [CFG_BITS-1:0] set_quiet[NUM_SETTINGS] =
		'{16'd1, 16'd3, 16'd1, 16'd7, 16'd7, 16'd2, 16'd1};

	stop_and_wait_arq_sender_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic result_t make_send(input logic [2:0] k, input seq_t s, input seq_t a);
		result_t r;
		r.out_kind = k;
		r.out_seq = s;
		r.out_ack = a;
		return r;
	endfunction

	// Advance the expected connection state by one event; return 1 when the
	// event should produce a send request or a status report.
	function automatic bit predict_step(input event_t ev, output result_t res);
		seq_t next_seq;
		bit is_last;
		res = '0;
		next_seq = tx_seq + 1'b1;
		case (ev.opcode)
		OP_TICK: begin
			// Closed and established run no timer.
			if (arq_phase == PH_CLOSED || arq_phase == PH_EST)
				return 0;
			tick_cnt = tick_cnt + 1'b1;
			if (tick_cnt < cfg_timeout)
				return 0;
			tick_cnt = '0;
			case (arq_phase)
			PH_SYN: begin
				res = make_send(K_SYN, tx_seq, '0);
				return 1;
			end
			PH_XFER: begin
				res = make_send(K_DATA, tx_seq, '0);
				return 1;
			end
			PH_FIN: begin
				res = make_send(K_FIN, tx_seq, '0);
				return 1;
			end
			PH_HQUIET, PH_FQUIET: begin
				if (quiet_cnt < QUIET_MAX)
					quiet_cnt = quiet_cnt + 1'b1;
				if (quiet_cnt < cfg_quiet)
					return 0;
				quiet_cnt = '0;
				if (arq_phase == PH_HQUIET) begin
					tx_seq = tx_seq + 1'b1;
					arq_phase = PH_EST;
					res = make_send(K_CONN, tx_seq, rx_next);
				end else begin
					arq_phase = PH_CLOSED;
					res = make_send(K_CLOSED, tx_seq, rx_next);
				end
				return 1;
			end
			default: return 0;
			endcase
		end
		OP_PKT: begin
			// Drop anything with a bad checksum before looking at it.
			if (!ev.pkt_sum_ok)
				return 0;
			case (arq_phase)
			PH_SYN: begin
				if (ev.pkt_kind != FLAG_SYNACK || ev.pkt_ack != next_seq)
					return 0;
				rx_next = ev.pkt_seq + 1'b1;
				tx_seq = next_seq;
				arq_phase = PH_HQUIET;
				tick_cnt = '0;
				quiet_cnt = '0;
				res = make_send(K_ACK, tx_seq, rx_next);
				return 1;
			end
			PH_HQUIET: begin
				if (ev.pkt_kind != FLAG_SYNACK || ev.pkt_ack != tx_seq)
					return 0;
				tick_cnt = '0;
				quiet_cnt = '0;
				res = make_send(K_ACK, tx_seq, rx_next);
				return 1;
			end
			PH_XFER: begin
				if (ev.pkt_kind != FLAG_ACK)
					return 0;
				tick_cnt = '0;
				// A wrong ack number resends the outstanding packet at once.
				if (ev.pkt_ack != next_seq) begin
					res = make_send(K_DATA, tx_seq, '0);
					return 1;
				end
				is_last = (tx_seq == last_seq);
				tx_seq = ev.pkt_ack;
				rx_next = ev.pkt_seq + 1'b1;
				if (is_last) begin
					arq_phase = PH_EST;
					res = make_send(K_DONE, tx_seq, rx_next);
				end else begin
					res = make_send(K_DATA, tx_seq, '0);
				end
				return 1;
			end
			PH_FIN: begin
				if (ev.pkt_kind != FLAG_ACK || ev.pkt_ack != next_seq)
					return 0;
				tx_seq = next_seq;
				rx_next = ev.pkt_seq + 1'b1;
				arq_phase = PH_FINACK;
				tick_cnt = '0;
				return 0;
			end
			PH_FINACK: begin
				if (ev.pkt_kind != FLAG_FINACK || ev.pkt_ack != tx_seq ||
						ev.pkt_seq != rx_next)
					return 0;
				rx_next = ev.pkt_seq + 1'b1;
				arq_phase = PH_FQUIET;
				tick_cnt = '0;
				quiet_cnt = '0;
				res = make_send(K_ACK, tx_seq, rx_next);
				return 1;
			end
			PH_FQUIET: begin
				// A repeated FIN-ACK carries the sequence number we already took.
				if (ev.pkt_kind != FLAG_FINACK || ev.pkt_ack != tx_seq ||
						seq_t'(ev.pkt_seq + 1'b1) != rx_next)
					return 0;
				tick_cnt = '0;
				quiet_cnt = '0;
				res = make_send(K_ACK, tx_seq, rx_next);
				return 1;
			end
			default: return 0;
			endcase
		end
		OP_OPEN: begin
			if (arq_phase != PH_CLOSED)
				return 0;
			tx_seq = '0;
			rx_next = '0;
			arq_phase = PH_SYN;
			tick_cnt = '0;
			quiet_cnt = '0;
			res = make_send(K_SYN, tx_seq, '0);
			return 1;
		end
		OP_XFER: begin
			if (arq_phase != PH_EST)
				return 0;
			last_seq = ev.final_seq;
			arq_phase = PH_XFER;
			tick_cnt = '0;
			res = make_send(K_DATA, tx_seq, '0);
			return 1;
		end
		OP_CLOSE: begin
			if (arq_phase != PH_EST)
				return 0;
			arq_phase = PH_FIN;
			tick_cnt = '0;
			res = make_send(K_FIN, tx_seq, '0);
			return 1;
		end
		default: return 0;
		endcase
	endfunction

	// Pick the next event from the current connection phase: mostly the reply
	// or command that moves the connection on, with random content in the
	// fields that do not matter, plus ticks and a share of pure noise.
	function automatic event_t next_event();
		event_t ev;
		int unsigned r;
		ev.opcode = OP_TICK;
		ev.pkt_kind = 8'($urandom);
		ev.pkt_seq = $urandom;
		ev.pkt_ack = $urandom;
		ev.pkt_sum_ok = ($urandom_range(0, 9) != 0);
		ev.final_seq = $urandom;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			ev.opcode = 3'($urandom_range(0, 7));
			case ($urandom_range(0, 3))
			0: ev.pkt_kind = FLAG_ACK;
			1: ev.pkt_kind = FLAG_SYNACK;
			2: ev.pkt_kind = FLAG_FINACK;
			default: ;
			endcase
			// Keep any transfer reachable to its end; a final number behind
			// the current one would run through the whole sequence space.
			if (ev.opcode == OP_XFER)
				ev.final_seq = tx_seq + $urandom_range(0, 4);
			return ev;
		end
		case (arq_phase)
		PH_CLOSED: begin
			if (r < 70)
				ev.opcode = OP_OPEN;
		end
		PH_SYN: begin
			if (r < 60) begin
				ev.opcode = OP_PKT;
				ev.pkt_kind = FLAG_SYNACK;
				ev.pkt_ack = tx_seq + 1'b1;
			end
		end
		PH_HQUIET: begin
			if (r < 17) begin
				ev.opcode = OP_PKT;
				ev.pkt_kind = FLAG_SYNACK;
				ev.pkt_ack = tx_seq;
			end
		end
		PH_EST: begin
			if (r < 55) begin
				ev.opcode = OP_XFER;
				ev.final_seq = tx_seq + $urandom_range(0, 4);
			end else if (r < 80) begin
				ev.opcode = OP_CLOSE;
			end
		end
		PH_XFER, PH_FIN: begin
			if (r < 65) begin
				ev.opcode = OP_PKT;
				ev.pkt_kind = FLAG_ACK;
				if (r >= 20)
					ev.pkt_ack = tx_seq + 1'b1;
			end
		end
		PH_FINACK: begin
			if (r < 65) begin
				ev.opcode = OP_PKT;
				ev.pkt_kind = FLAG_FINACK;
				ev.pkt_ack = tx_seq;
				if (r >= 18)
					ev.pkt_seq = rx_next;
			end
		end
		PH_FQUIET: begin
			if (r < 17) begin
				ev.opcode = OP_PKT;
				ev.pkt_kind = FLAG_FINACK;
				ev.pkt_ack = tx_seq;
				ev.pkt_seq = rx_next - 1'b1;
			end
		end
		default: ;
		endcase
		return ev;
	endfunction

	function automatic void add_event(input row_kind_t rk, input logic [2:0] op,
			input logic [7:0] kind, input seq_t s, input seq_t a, input logic ok,
			input seq_t fin, input bit has, input logic [2:0] ek, input seq_t es,
			input seq_t ea);
		script_row_t row;
		row.rk = rk;
		row.ev.opcode = op;
		row.ev.pkt_kind = kind;
		row.ev.pkt_seq = s;
		row.ev.pkt_ack = a;
		row.ev.pkt_sum_ok = ok;
		row.ev.final_seq = fin;
		row.has_send = has;
		row.send = make_send(ek, es, ea);
		row.cfg_idx = 1'b0;
		row.cfg_val = '0;
		script.push_back(row);
	endfunction

	function automatic void add_config(input logic idx, input logic [CFG_BITS-1:0] val);
		script_row_t row;
		row.rk = ROW_CONFIG;
		row.ev = '0;
		row.has_send = 0;
		row.send = '0;
		row.cfg_idx = idx;
		row.cfg_val = val;
		script.push_back(row);
	endfunction

	// Offer one event on the slave side, after a random gap unless the
	// current stretch runs without idling, and hold it until the transfer.
	task automatic send_event(input event_t ev);
		int unsigned gap;
		int unsigned r;
		gap = 0;
		r = $urandom_range(0, 99);
		if (!steady && r >= 70)
			gap = (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = ev.opcode;
		s_axis_tdata = {7'b0, ev.final_seq, ev.pkt_sum_ok, ev.pkt_ack, ev.pkt_seq,
			ev.pkt_kind};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Send an event and queue whatever the connection should put out for it.
	task automatic issue(input event_t ev);
		result_t r;
		send_event(ev);
		if (predict_step(ev, r))
			pending_sends.push_back(r);
	endtask

	// Write a register only with nothing in flight: drop valid, drain every
	// expected send, then give the pipeline time for events with no output.
	task automatic program_reg(input logic idx, input logic [CFG_BITS-1:0] val);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_sends.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_TIMEOUT)
			cfg_timeout = val;
		else
			cfg_quiet = val[QUIET_BITS-1:0];
	endtask

	// Check every master-side transfer against the oldest expected send.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sends_seen++;
			if (pending_sends.size() == 0) begin
				$error("unexpected transfer: out_kind %0d out_seq %h out_ack %h",
					m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
				error_count++;
			end else begin
				want = pending_sends.pop_front();
				if (m_axis_tuser !== want.out_kind) begin
					$error("out_kind: expected %0d, got %0d", want.out_kind, m_axis_tuser);
					error_count++;
				end
				if (m_axis_tdata[31:0] !== want.out_seq) begin
					$error("out_seq: expected %h, got %h", want.out_seq, m_axis_tdata[31:0]);
					error_count++;
				end
				if (m_axis_tdata[63:32] !== want.out_ack) begin
					$error("out_ack: expected %h, got %h", want.out_ack, m_axis_tdata[63:32]);
					error_count++;
				end
			end
		end
	end

	// Receiver: random stalls, mostly short and a few long, no stalls at all in
	// steady stretches, and one long hold-off that fills the output buffer and
	// backs up the input while the sender keeps offering events.
	initial begin
		int unsigned r;
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (!held_off && sends_seen >= HOLD_AFTER) begin
				held_off = 1;
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (steady || r < 60) begin
				m_axis_tready = 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end else if (r < 95) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end else begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(10, 60)) @(negedge clk);
			end
		end
	end

	// Stimulus: directed walk through the protocol, then random phases under
	// a range of timer settings, then a transfer whose final number lies behind.
	initial begin
		event_t ev;
		result_t scratch;
		int guard;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = '0;
		arq_phase = PH_CLOSED;
		tx_seq = '0;
		rx_next = '0;
		last_seq = '0;
		tick_cnt = '0;
		quiet_cnt = '0;
		cfg_timeout = TIMEOUT_RESET;
		cfg_quiet = QUIET_RESET;

		// Closed: every command but open, unknown opcodes and stray packets do
		// nothing. Fields at their extremes ride along.
		add_event(ROW_TYPED, OP_TICK, 8'h00, '0, '0, 1'b0, '0, 0, K_SYN, '0, '0);
		add_event(ROW_TYPED, OP_RSVD_HI, 8'hFF, '1, '1, 1'b1, '1, 0, K_SYN, '0, '0);
		add_event(ROW_TYPED, OP_RSVD_LO, 8'h00, '0, '0, 1'b0, '0, 0, K_SYN, '0, '0);
		add_event(ROW_TYPED, OP_PKT, 8'hFF, '1, '1, 1'b1, '1, 0, K_SYN, '0, '0);
		add_event(ROW_TYPED, OP_XFER, 8'h00, '0, '0, 1'b0, '1, 0, K_SYN, '0, '0);
		add_event(ROW_TYPED, OP_CLOSE, 8'h00, '0, '0, 1'b0, '0, 0, K_SYN, '0, '0);
		// Open, then a second open in the wrong phase.
		add_event(ROW_TYPED, OP_OPEN, 8'h00, '0, '0, 1'b0, '0, 1, K_SYN, '0, '0);
		add_event(ROW_TYPED, OP_OPEN, 8'h00, '0, '0, 1'b0, '0, 0, K_SYN, '0, '0);
		// Bad checksum, wrong flag and wrong ack number are all dropped.
		add_event(ROW_TYPED, OP_PKT, FLAG_SYNACK, '0, 32'd1, 1'b0, '0, 0, K_SYN, '0, '0);
		add_event(ROW_TYPED, OP_PKT, FLAG_ACK, '0, 32'd1, 1'b1, '0, 0, K_SYN, '0, '0);
		add_event(ROW_TYPED, OP_PKT, FLAG_SYNACK, '0, 32'd2, 1'b1, '0, 0, K_SYN, '0, '0);
		add_event(ROW_PREDICTED, OP_TICK, 8'h00, '0, '0, 1'b1, '0, 0, K_SYN, '0, '0);
		// SYN-ACK at the top of the sequence space: peer number wraps to zero.
		add_event(ROW_TYPED, OP_PKT, FLAG_SYNACK, '1, 32'd1, 1'b1, '0, 1, K_ACK, 32'd1, '0);
		// Duplicate SYN-ACK resends the ACK; one with a stale ack does not.
		add_event(ROW_TYPED, OP_PKT, FLAG_SYNACK, '1, 32'd1, 1'b1, '0, 1, K_ACK, 32'd1, '0);
		add_event(ROW_TYPED, OP_PKT, FLAG_SYNACK, '1, 32'd2, 1'b1, '0, 0, K_SYN, '0, '0);
		// Shortest timeout: two silent ticks finish the handshake.
		add_config(CFG_TIMEOUT, 16'd1);
		add_event(ROW_PREDICTED, OP_TICK, 8'h00, '0, '0, 1'b0, '0, 0, K_SYN, '0, '0);
		add_event(ROW_TYPED, OP_TICK, 8'h00, '0, '0, 1'b0, '0, 1, K_CONN, 32'd2, '0);
		// One-packet transfer: wrong ack and a timeout both resend the data.
		add_event(ROW_TYPED, OP_XFER, 8'h00, '0, '0, 1'b0, 32'd2, 1, K_DATA, 32'd2, '0);
		add_event(ROW_TYPED, OP_PKT, FLAG_ACK, '0, 32'd5, 1'b1, '0, 1, K_DATA, 32'd2, '0);
		add_event(ROW_PREDICTED, OP_TICK, 8'h00, '0, '0, 1'b0, '0, 0, K_SYN, '0, '0);
		add_event(ROW_TYPED, OP_PKT, FLAG_ACK, 32'd10, 32'd3, 1'b1, '0, 1, K_DONE, 32'd3,
			32'd11);
		// Teardown: FIN, its resend, the ACK, a FIN-ACK out of order, the
		// FIN-ACK, and its duplicate.
		add_event(ROW_TYPED, OP_CLOSE, 8'h00, '0, '0, 1'b0, '0, 1, K_FIN, 32'd3, '0);
		add_event(ROW_PREDICTED, OP_TICK, 8'h00, '0, '0, 1'b0, '0, 0, K_SYN, '0, '0);
		add_event(ROW_TYPED, OP_PKT, FLAG_ACK, 32'd20, 32'd4, 1'b1, '0, 0, K_SYN, '0, '0);
		add_event(ROW_TYPED, OP_PKT, FLAG_FINACK, 32'd20, 32'd4, 1'b1, '0, 0, K_SYN, '0, '0);
		add_event(ROW_TYPED, OP_PKT, FLAG_FINACK, 32'd21, 32'd4, 1'b1, '0, 1, K_ACK, 32'd4,
			32'd22);
		add_event(ROW_TYPED, OP_PKT, FLAG_FINACK, 32'd21, 32'd4, 1'b1, '0, 1, K_ACK, 32'd4,
			32'd22);
		// Zero quiet count: the first silent timeout closes.
		add_config(CFG_QUIET, 16'd0);
		add_event(ROW_TYPED, OP_TICK, 8'h00, '0, '0, 1'b0, '0, 1, K_CLOSED, 32'd4, 32'd22);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (script[i]) begin
			case (script[i].rk)
			ROW_CONFIG: program_reg(script[i].cfg_idx, script[i].cfg_val);
			ROW_TYPED: begin
				send_event(script[i].ev);
				void'(predict_step(script[i].ev, scratch));
				if (script[i].has_send)
					pending_sends.push_back(script[i].send);
			end
			default: issue(script[i].ev);
			endcase
		end

		// Random phases; every third one runs both sides without idling.
		for (int s = 0; s < NUM_SETTINGS; s++) begin
			steady = (s % 3 == 1);
			program_reg(CFG_TIMEOUT, set_timeout[s]);
			program_reg(CFG_QUIET, set_quiet[s]);
			repeat (ITEMS_PER_SETTING) issue(next_event());
		end
		steady = 0;

		// Final number behind the current one: the transfer must keep going
		// past it. It never ends, so this comes last.
		guard = 0;
		while (arq_phase != PH_EST && guard < 2000) begin
			issue(next_event());
			guard++;
		end
		if (arq_phase == PH_EST) begin
			ev = '0;
			ev.opcode = OP_XFER;
			ev.final_seq = tx_seq - 1'b1;
			issue(ev);
			repeat (4) begin
				ev = '0;
				ev.opcode = OP_PKT;
				ev.pkt_kind = FLAG_ACK;
				ev.pkt_sum_ok = 1'b1;
				ev.pkt_seq = $urandom;
				ev.pkt_ack = tx_seq + 1'b1;
				issue(ev);
			end
		end

		// Drain and let the pipeline settle before the verdict.
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_sends.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog: generous bound well past the slowest legal run.
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
